>>> hdl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

    localparam int DATA_W = 32;
    localparam int DEN_W  = 31;
    localparam int CNT_W  = 5;

    typedef enum logic [2:0] {
        MODE_ADD  = 3'd0,
        MODE_SUB  = 3'd1,
        MODE_MUL  = 3'd2,
        MODE_DIV  = 3'd3,
        MODE_CMP  = 3'd4,
        MODE_NORM = 3'd5
    } mode_t;

    typedef struct packed {
        logic [2:0]               mode;
        logic signed [DATA_W-1:0] a_num;
        logic signed [DATA_W-1:0] a_den;
        logic signed [DATA_W-1:0] b_num;
        logic [DEN_W-1:0]         b_den;
    } rau_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_num;
        logic [DEN_W-1:0]         result_den;
        logic                     is_equal;
        logic                     is_less;
        logic                     is_greater;
    } rau_rsp_t;

endpackage

>>> hdl/rau_stream_if.sv
// Valid/ready channel carrying one request or response payload.
interface rau_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/rational_arithmetic_unit.sv
// Rational arithmetic unit: one shared gcd, divider and multiplier under a sequencer.
// Infinity/zero special cases and unused modes give the result in the cycle after accept.
// Add, subtract, compare: one binary gcd, then two restoring divides and three multiplies;
// multiply and divide run two gcds, four divides and two multiplies; normalize runs one gcd
// and two divides.
// Throughput: one request at a time, set by the shared gcd and divider; a new request is taken
// in the cycle its predecessor's response is taken. rst_n clears control and output valid.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rau_stream_if.sink   req,
    rau_stream_if.source rsp
);

    typedef enum logic [2:0] {
        S_IDLE, S_GLOAD, S_GCD, S_DLOAD, S_DIV, S_MUL, S_FIN, S_DONE
    } state_t;

    localparam logic [DATA_W-1:0] ONE       = DATA_W'(1);
    localparam logic [DATA_W-1:0] MINUS_ONE = '1;
    localparam logic [DATA_W-1:0] ZERO      = '0;

    function automatic logic [DATA_W-1:0] neg(input logic [DATA_W-1:0] x);
        neg = ~x + ONE;
    endfunction

    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
        mag = x[DATA_W-1] ? neg(x) : x;
    endfunction

    // control state
    state_t             state_reg, state_next;
    logic [2:0]         mode_reg, mode_next;
    logic [1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               valid_reg, valid_next;
    logic [DATA_W-1:0]  rn_reg, rn_next;
    logic [DEN_W-1:0]   rd_reg, rd_next;
    logic               eq_reg, eq_next;
    logic               lt_reg, lt_next;
    logic               gt_reg, gt_next;

    // datapath
    logic [DATA_W-1:0]  op0_reg, op1_reg, op2_reg, op3_reg;
    logic [DATA_W-1:0]  op0_next, op1_next, op2_next, op3_next;
    logic [DATA_W-1:0]  q0_reg, q1_reg, q2_reg, q3_reg;
    logic [DATA_W-1:0]  q0_next, q1_next, q2_next, q3_next;
    logic [DATA_W-1:0]  g0_reg, g1_reg, g0_next, g1_next;
    logic [DATA_W-1:0]  p0_reg, p1_reg, p2_reg, p0_next, p1_next, p2_next;
    logic [DATA_W-1:0]  u_reg, v_reg, u_next, v_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [DATA_W-1:0]  rem_reg, quo_reg, rem_next, quo_next;
    logic               cmp_eq_reg, cmp_eq_next;
    logic               bneg_reg, bneg_next;

    // request decode
    logic [DATA_W-1:0]  an, ad, bn, bd;
    logic               a_pos, b_pos;
    logic [DATA_W-1:0]  su;
    logic               spec_hit;
    logic [DATA_W-1:0]  spec_num;
    logic               in_eq;
    logic               accept;

    // shared units
    logic [DATA_W-1:0]  sel_op, divisor, mul_a, mul_b, mul_out, g_val;
    logic               gcd_done;
    logic [DATA_W:0]    rem_sh, diff;
    logic               ge;
    logic               mul_family, is_last_gcd, is_last_div, is_last_mul;
    logic [DATA_W-1:0]  fin_num, fin_den;

    assign req.ready   = (state_reg == S_IDLE) || (state_reg == S_DONE && rsp.ready);
    assign accept      = req.valid && req.ready;
    assign rsp.valid   = valid_reg;
    assign rsp.payload = '{result_num: rn_reg, result_den: rd_reg,
                           is_equal: eq_reg, is_less: lt_reg, is_greater: gt_reg};

    assign an    = req.payload.a_num;
    assign ad    = req.payload.a_den;
    assign bn    = req.payload.b_num;
    assign bd    = {1'b0, req.payload.b_den};
    assign a_pos = (an != ZERO) && !an[DATA_W-1];
    assign b_pos = (bn != ZERO) && !bn[DATA_W-1];
    assign su    = (a_pos == b_pos) ? ONE : MINUS_ONE;

    // equal: same-signed infinities, or bit-equal fields
    assign in_eq = ((ad == ZERO) && (bd == ZERO) &&
                    ((an[DATA_W-1] && bn[DATA_W-1]) || (a_pos && b_pos)))
                   || ((an == bn) && (ad == bd));

    // infinity/zero rules and unused modes that bypass the arithmetic
    always_comb
    begin
        spec_hit = 1'b0;
        spec_num = ZERO;
        case (req.payload.mode)
            MODE_ADD, MODE_SUB, MODE_CMP:
            begin
                if (ad == ZERO)
                begin
                    spec_hit = 1'b1;
                    spec_num = an;
                end
                else if (bd == ZERO)
                begin
                    spec_hit = 1'b1;
                    spec_num = (req.payload.mode == MODE_ADD) ? bn : neg(bn);
                end
            end
            MODE_MUL:
            begin
                if (ad == ZERO)
                begin
                    spec_hit = 1'b1;
                    spec_num = (an == ZERO || bn == ZERO) ? ZERO : su;
                end
                else if (bd == ZERO)
                begin
                    spec_hit = 1'b1;
                    spec_num = su;
                end
            end
            MODE_DIV:
            begin
                if (ad == ZERO)
                begin
                    spec_hit = 1'b1;
                    spec_num = (an == ZERO || bd == ZERO) ? ZERO : su;
                end
                else if (bn == ZERO)
                begin
                    spec_hit = 1'b1;
                    spec_num = a_pos ? ONE : (an[DATA_W-1] ? MINUS_ONE : ZERO);
                end
            end
            MODE_NORM: spec_hit = 1'b0;
            default:   spec_hit = 1'b1;
        endcase
    end

    // sequencing limits per mode
    assign mul_family  = (mode_reg == MODE_MUL) || (mode_reg == MODE_DIV);
    assign is_last_gcd = mul_family ? (idx_reg == 2'd1) : (idx_reg == 2'd0);
    assign is_last_div = mul_family ? (idx_reg == 2'd3) : (idx_reg == 2'd1);
    assign is_last_mul = mul_family ? (idx_reg == 2'd1) : (idx_reg == 2'd2);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_op = op0_reg;
            2'd1:    sel_op = op1_reg;
            2'd2:    sel_op = op2_reg;
            default: sel_op = op3_reg;
        endcase
    end

    assign divisor = idx_reg[1] ? g1_reg : g0_reg;

    // binary gcd step
    always_comb
    begin
        gcd_done = 1'b0;
        g_val    = ZERO;
        u_next   = u_reg;
        v_next   = v_reg;
        k_next   = k_reg;
        if (v_reg == ZERO)
        begin
            gcd_done = 1'b1;
            g_val    = (u_reg == ZERO) ? ONE : (u_reg << k_reg);
        end
        else if (u_reg == ZERO)
        begin
            gcd_done = 1'b1;
            g_val    = v_reg << k_reg;
        end
        else if (!u_reg[0] && !v_reg[0])
        begin
            u_next = u_reg >> 1;
            v_next = v_reg >> 1;
            k_next = k_reg + 1'b1;
        end
        else if (!u_reg[0])
            u_next = u_reg >> 1;
        else if (!v_reg[0])
            v_next = v_reg >> 1;
        else if (u_reg >= v_reg)
            u_next = u_reg - v_reg;
        else
            v_next = v_reg - u_reg;
    end

    // restoring divider step
    assign rem_sh = {rem_reg, quo_reg[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, divisor};
    assign ge     = !diff[DATA_W];

    // shared multiplier operand select
    always_comb
    begin
        mul_a = q0_reg;
        mul_b = q2_reg;
        case (mode_reg)
            MODE_MUL:
            begin
                mul_a = idx_reg[0] ? q3_reg : q0_reg;
                mul_b = idx_reg[0] ? q1_reg : q2_reg;
            end
            MODE_DIV:
            begin
                mul_a = idx_reg[0] ? q3_reg : q0_reg;
                if (idx_reg[0])
                    mul_b = bneg_reg ? neg(q1_reg) : q1_reg;
                else
                    mul_b = bneg_reg ? neg(q2_reg) : q2_reg;
            end
            default:
            begin
                case (idx_reg)
                    2'd0:    begin mul_a = op2_reg; mul_b = q1_reg; end
                    2'd1:    begin mul_a = op3_reg; mul_b = q0_reg; end
                    default: begin mul_a = op0_reg; mul_b = q1_reg; end
                endcase
            end
        endcase
    end

    assign mul_out = mul_a * mul_b;

    always_comb
    begin
        case (mode_reg)
            MODE_ADD:           begin fin_num = p0_reg + p1_reg; fin_den = p2_reg; end
            MODE_SUB, MODE_CMP: begin fin_num = p0_reg - p1_reg; fin_den = p2_reg; end
            MODE_MUL, MODE_DIV: begin fin_num = p0_reg;          fin_den = p1_reg; end
            default:            begin fin_num = q0_reg;          fin_den = q1_reg; end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        valid_next  = valid_reg;
        rn_next     = rn_reg;
        rd_next     = rd_reg;
        eq_next     = eq_reg;
        lt_next     = lt_reg;
        gt_next     = gt_reg;
        op0_next    = op0_reg;
        op1_next    = op1_reg;
        op2_next    = op2_reg;
        op3_next    = op3_reg;
        q0_next     = q0_reg;
        q1_next     = q1_reg;
        q2_next     = q2_reg;
        q3_next     = q3_reg;
        g0_next     = g0_reg;
        g1_next     = g1_reg;
        p0_next     = p0_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cmp_eq_next = cmp_eq_reg;
        bneg_next   = bneg_reg;

        if (state_reg == S_DONE && rsp.ready)
        begin
            valid_next = 1'b0;
            state_next = S_IDLE;
        end

        case (state_reg)
            S_GLOAD:
            begin
                state_next = S_GCD;
            end
            S_GCD:
            begin
                if (gcd_done)
                begin
                    if (idx_reg[0])
                        g1_next = g_val;
                    else
                        g0_next = g_val;
                    if (is_last_gcd)
                    begin
                        idx_next   = 2'd0;
                        state_next = S_DLOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_GLOAD;
                    end
                end
            end
            S_DLOAD:
            begin
                quo_next   = mag(sel_op);
                rem_next   = ZERO;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    case (idx_reg)
                        2'd0:    q0_next = sel_op[DATA_W-1] ? neg(quo_next) : quo_next;
                        2'd1:    q1_next = sel_op[DATA_W-1] ? neg(quo_next) : quo_next;
                        2'd2:    q2_next = sel_op[DATA_W-1] ? neg(quo_next) : quo_next;
                        default: q3_next = sel_op[DATA_W-1] ? neg(quo_next) : quo_next;
                    endcase
                    if (is_last_div)
                    begin
                        idx_next   = 2'd0;
                        state_next = (mode_reg == MODE_NORM) ? S_FIN : S_MUL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_DLOAD;
                    end
                end
            end
            S_MUL:
            begin
                case (idx_reg)
                    2'd0:    p0_next = mul_out;
                    2'd1:    p1_next = mul_out;
                    default: p2_next = mul_out;
                endcase
                if (is_last_mul)
                    state_next = S_FIN;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_FIN:
            begin
                rn_next    = fin_num;
                rd_next    = fin_den[DEN_W-1:0];
                eq_next    = (mode_reg == MODE_CMP) && cmp_eq_reg;
                lt_next    = (mode_reg == MODE_CMP) && fin_num[DATA_W-1];
                gt_next    = (mode_reg == MODE_CMP) && (fin_num != ZERO)
                             && !fin_num[DATA_W-1];
                valid_next = 1'b1;
                state_next = S_DONE;
            end
            default:
            begin
            end
        endcase

        if (accept)
        begin
            mode_next   = req.payload.mode;
            cmp_eq_next = in_eq;
            bneg_next   = bn[DATA_W-1];
            idx_next    = 2'd0;
            case (req.payload.mode)
                MODE_MUL:
                begin
                    op0_next = an; op1_next = bd; op2_next = bn; op3_next = ad;
                end
                MODE_DIV:
                begin
                    op0_next = an; op1_next = bn; op2_next = bd; op3_next = ad;
                end
                MODE_NORM:
                begin
                    op0_next = ad[DATA_W-1] ? neg(an) : an;
                    op1_next = ad[DATA_W-1] ? neg(ad) : ad;
                    op2_next = an; op3_next = ad;
                end
                default:
                begin
                    op0_next = ad; op1_next = bd; op2_next = an; op3_next = bn;
                end
            endcase
            if (spec_hit)
            begin
                rn_next    = spec_num;
                rd_next    = '0;
                eq_next    = (req.payload.mode == MODE_CMP) && in_eq;
                lt_next    = (req.payload.mode == MODE_CMP) && spec_num[DATA_W-1];
                gt_next    = (req.payload.mode == MODE_CMP) && (spec_num != ZERO)
                             && !spec_num[DATA_W-1];
                valid_next = 1'b1;
                state_next = S_DONE;
            end
            else
            begin
                valid_next = 1'b0;
                state_next = S_GLOAD;
            end
        end
    end

    // gcd operands load from the selected operand pair
    logic [DATA_W-1:0] gl_u, gl_v;
    assign gl_u = idx_reg[0] ? mag(op2_reg) : mag(op0_reg);
    assign gl_v = idx_reg[0] ? mag(op3_reg) : mag(op1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= '0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            rn_reg    <= '0;
            rd_reg    <= '0;
            eq_reg    <= 1'b0;
            lt_reg    <= 1'b0;
            gt_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            rn_reg    <= rn_next;
            rd_reg    <= rd_next;
            eq_reg    <= eq_next;
            lt_reg    <= lt_next;
            gt_reg    <= gt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op0_reg    <= op0_next;
        op1_reg    <= op1_next;
        op2_reg    <= op2_next;
        op3_reg    <= op3_next;
        q0_reg     <= q0_next;
        q1_reg     <= q1_next;
        q2_reg     <= q2_next;
        q3_reg     <= q3_next;
        g0_reg     <= g0_next;
        g1_reg     <= g1_next;
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cmp_eq_reg <= cmp_eq_next;
        bneg_reg   <= bneg_next;
        if (state_reg == S_GLOAD)
        begin
            u_reg <= gl_u;
            v_reg <= gl_v;
            k_reg <= '0;
        end
        else
        begin
            u_reg <= u_next;
            v_reg <= v_next;
            k_reg <= k_next;
        end
    end

    // flags only ever come out of a compare request
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (mode_reg != MODE_CMP) |-> !(eq_reg || lt_reg || gt_reg))
        else $error("compare flags set outside compare");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !(lt_reg && gt_reg))
        else $error("less and greater both set");

    // a gcd is never zero, so the divider never sees a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (divisor != ZERO))
        else $error("divide by zero gcd");

    // no response is shown while the units are still working
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DONE) |-> !valid_reg)
        else $error("response valid outside done");

endmodule

>>> tb/tb_rational_arithmetic_unit.sv
// Testbench for the rational arithmetic unit: directed and random requests checked against a predictor.
module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    logic clk;
    logic rst_n;

    rau_stream_if #(.payload_t(rau_req_t)) req_ch ();
    rau_stream_if #(.payload_t(rau_rsp_t)) rsp_ch ();

    rational_arithmetic_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    localparam int WATCHDOG_LIMIT = 20000;

    rau_rsp_t expected_q[$];
    int       fail_count;
    int       stall_cycles;
    bit       idle_enable;
    bit       timed_out;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ---------------------------------------------------------------
    // Predictor helpers, 32-bit two's complement wrapping arithmetic
    // ---------------------------------------------------------------
    function automatic logic [31:0] mag32(logic [31:0] x);
        return x[31] ? -x : x;
    endfunction

    function automatic logic [31:0] euclid_gcd(logic [31:0] x, logic [31:0] y);
        logic [31:0] p;
        logic [31:0] q;
        logic [31:0] t;
        p = mag32(x);
        q = mag32(y);
        if (p < q)
        begin
            t = p;
            p = q;
            q = t;
        end
        if (p == 0)
            return 32'd1;
        while (q != 0 && q != 1)
        begin
            t = q;
            q = p % q;
            p = t;
        end
        return (q == 1) ? 32'd1 : p;
    endfunction

    // signed value over a magnitude, truncating toward zero
    function automatic logic [31:0] div_mag(logic [31:0] x, logic [31:0] r);
        logic [31:0] quo;
        quo = mag32(x) / r;
        return x[31] ? -quo : quo;
    endfunction

    function automatic bit is_pos(logic [31:0] x);
        return x != 0 && !x[31];
    endfunction

    function automatic void sum_fraction(logic [31:0] an, logic [31:0] ad,
                                         logic [31:0] bn, logic [31:0] bd, bit negate_b,
                                         output logic [31:0] rn, output logic [31:0] rd);
        logic [31:0] g;
        logic [31:0] sb;
        logic [31:0] sa;
        logic [31:0] term;
        if (ad == 0)
        begin
            rn = an;
            rd = 0;
        end
        else if (bd == 0)
        begin
            rn = negate_b ? -bn : bn;
            rd = 0;
        end
        else
        begin
            g    = euclid_gcd(ad, bd);
            sb   = div_mag(bd, g);
            sa   = div_mag(ad, g);
            term = bn * sa;
            rn   = negate_b ? an * sb - term : an * sb + term;
            rd   = ad * sb;
        end
    endfunction

    function automatic rau_rsp_t predict_fraction(rau_req_t r);
        rau_rsp_t    o;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] bn;
        logic [31:0] bd;
        logic [31:0] rn;
        logic [31:0] rd;
        logic [31:0] g1;
        logic [31:0] g2;
        bit          same;
        bit          eq;
        an   = r.a_num;
        ad   = r.a_den;
        bn   = r.b_num;
        bd   = {1'b0, r.b_den};
        rn   = 0;
        rd   = 0;
        eq   = 0;
        same = (is_pos(an) == is_pos(bn));
        o    = '0;
        case (r.mode)
            MODE_ADD:
                sum_fraction(an, ad, bn, bd, 1'b0, rn, rd);
            MODE_SUB:
                sum_fraction(an, ad, bn, bd, 1'b1, rn, rd);
            MODE_MUL:
            begin
                if (ad == 0)
                    rn = (an == 0 || bn == 0) ? 32'd0 : (same ? 32'd1 : -32'd1);
                else if (bd == 0)
                    rn = same ? 32'd1 : -32'd1;
                else
                begin
                    g1 = euclid_gcd(an, bd);
                    g2 = euclid_gcd(bn, ad);
                    rn = div_mag(an, g1) * div_mag(bn, g2);
                    rd = div_mag(ad, g2) * div_mag(bd, g1);
                end
            end
            MODE_DIV:
            begin
                if (ad == 0)
                    rn = (an == 0 || bd == 0) ? 32'd0 : (same ? 32'd1 : -32'd1);
                else if (bn == 0)
                    rn = is_pos(an) ? 32'd1 : (an[31] ? -32'd1 : 32'd0);
                else
                begin
                    g1 = euclid_gcd(an, bn);
                    g2 = euclid_gcd(bd, ad);
                    rn = div_mag(an, g1);
                    rd = div_mag(ad, g2);
                    if (bn[31])
                    begin
                        rn = rn * -div_mag(bd, g2);
                        rd = rd * -div_mag(bn, g1);
                    end
                    else
                    begin
                        rn = rn * div_mag(bd, g2);
                        rd = rd * div_mag(bn, g1);
                    end
                end
            end
            MODE_CMP:
            begin
                if (ad == 0 && bd == 0 && ((an[31] && bn[31]) || (is_pos(an) && is_pos(bn))))
                    eq = 1;
                else
                    eq = (an == bn && ad == bd);
                sum_fraction(an, ad, bn, bd, 1'b1, rn, rd);
                o.is_equal   = eq;
                o.is_less    = rn[31];
                o.is_greater = is_pos(rn);
            end
            MODE_NORM:
            begin
                if (ad[31])
                begin
                    an = -an;
                    ad = -ad;
                end
                g1 = euclid_gcd(an, ad);
                rn = div_mag(an, g1);
                rd = div_mag(ad, g1);
            end
            default:
            begin
                rn = 0;
                rd = 0;
            end
        endcase
        o.result_num = rn;
        o.result_den = rd[30:0];
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Driving, checking, watchdog
    // ---------------------------------------------------------------
    // valid stays up from one request to the next when there is no gap
    task automatic send_request(logic [2:0] md, logic [31:0] an, logic [31:0] ad,
                                logic [31:0] bn, logic [30:0] bd);
        rau_req_t r;
        int       gap;
        r.mode  = md;
        r.a_num = an;
        r.a_den = ad;
        r.b_num = bn;
        r.b_den = bd;
        // random sender gaps in bursts
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_q.push_back(predict_fraction(r));
    endtask

    // receiver stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_cycles <= 0;
        end
        else if (stall_cycles > 0)
        begin
            stall_cycles <= stall_cycles - 1;
            rsp_ch.ready <= (stall_cycles == 1);
        end
        else if (idle_enable && $urandom_range(0, 7) == 0)
        begin
            stall_cycles <= $urandom_range(1, 19);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        rau_rsp_t exp_rsp;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, actual %h", $time,
                         rsp_ch.payload);
                fail_count++;
            end
            else
            begin
                exp_rsp = expected_q.pop_front();
                if (rsp_ch.payload.result_num !== exp_rsp.result_num)
                begin
                    $display("%0t: result_num expected %h actual %h", $time,
                             exp_rsp.result_num, rsp_ch.payload.result_num);
                    fail_count++;
                end
                if (rsp_ch.payload.result_den !== exp_rsp.result_den)
                begin
                    $display("%0t: result_den expected %h actual %h", $time,
                             exp_rsp.result_den, rsp_ch.payload.result_den);
                    fail_count++;
                end
                if (rsp_ch.payload.is_equal !== exp_rsp.is_equal)
                begin
                    $display("%0t: is_equal expected %b actual %b", $time,
                             exp_rsp.is_equal, rsp_ch.payload.is_equal);
                    fail_count++;
                end
                if (rsp_ch.payload.is_less !== exp_rsp.is_less)
                begin
                    $display("%0t: is_less expected %b actual %b", $time,
                             exp_rsp.is_less, rsp_ch.payload.is_less);
                    fail_count++;
                end
                if (rsp_ch.payload.is_greater !== exp_rsp.is_greater)
                begin
                    $display("%0t: is_greater expected %b actual %b", $time,
                             exp_rsp.is_greater, rsp_ch.payload.is_greater);
                    fail_count++;
                end
            end
        end
    end

    // counts cycles with no request or response taken
    always @(posedge clk)
    begin
        int quiet;
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            timed_out = 1'b1;
            $display("rational_arithmetic_unit: mismatch");
            $finish;
        end
    end

    // drops valid after the last request and waits for every response
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Value pickers
    // ---------------------------------------------------------------
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 40);
            2: return -$urandom_range(0, 40);
            3: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
            4: return 32'($urandom_range(0, 3)) * 32'h7fff_ffff + 32'($urandom_range(0, 2));
            default: return $urandom_range(1, 1000) * (32'd1 << $urandom_range(0, 8));
        endcase
    endfunction

    function automatic logic [30:0] pick_den();
        case ($urandom_range(0, 5))
            0: return 31'd0;
            1: return 31'($urandom_range(1, 60));
            2: return 31'($urandom);
            3: return 31'h7fff_ffff;
            default: return 31'($urandom_range(1, 1000) * (32'd1 << $urandom_range(0, 8)));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed_cases();
        send_request(MODE_ADD, 32'd1, 32'd2, 32'd1, 31'd3);
        send_request(MODE_ADD, 32'd5, 32'd0, 32'd7, 31'd3);        // infinite A
        send_request(MODE_ADD, 32'd5, 32'd4, -32'd7, 31'd0);       // infinite B
        send_request(MODE_SUB, -32'd3, 32'd0, 32'd7, 31'd0);
        send_request(MODE_SUB, 32'd5, 32'd6, 32'h8000_0000, 31'd0); // negate most negative
        send_request(MODE_SUB, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
        send_request(MODE_MUL, 32'd0, 32'd0, 32'd4, 31'd5);        // zero over zero
        send_request(MODE_MUL, -32'd2, 32'd0, 32'd0, 31'd5);
        send_request(MODE_MUL, -32'd2, 32'd0, 32'd9, 31'd5);
        send_request(MODE_MUL, 32'd3, 32'd4, -32'd8, 31'd0);
        send_request(MODE_MUL, 32'h8000_0000, 32'd6, 32'h8000_0000, 31'd4);
        send_request(MODE_DIV, 32'd3, 32'd0, 32'd2, 31'd0);
        send_request(MODE_DIV, -32'd3, 32'd0, 32'd2, 31'd7);
        send_request(MODE_DIV, -32'd3, 32'd5, 32'd0, 31'd7);       // divide by zero
        send_request(MODE_DIV, 32'd0, 32'd5, 32'd0, 31'd7);
        send_request(MODE_DIV, 32'd6, 32'd35, -32'd14, 31'd15);    // sign moved up
        send_request(MODE_DIV, 32'd0, 32'd1, 32'd0, 31'd0);        // zero A divided by zero B
        send_request(MODE_CMP, 32'd4, 32'd0, 32'd9, 31'd0);        // equal infinities
        send_request(MODE_CMP, 32'd1, 32'd2, 32'd2, 31'd4);        // equal unreduced: no
        send_request(MODE_CMP, 32'd3, 32'd7, 32'd3, 31'd7);
        send_request(MODE_CMP, -32'd1, 32'd3, 32'd1, 31'd3);
        send_request(MODE_NORM, 32'd6, -32'd8, 32'd0, 31'd0);
        send_request(MODE_NORM, 32'h8000_0000, 32'h8000_0000, 32'd1, 31'd1);
        send_request(MODE_NORM, 32'd0, 32'd0, 32'd0, 31'd0);
        send_request(3'd6, 32'd1, 32'd1, 32'd1, 31'd1);            // unused codes
        send_request(3'd7, -32'd1, -32'd1, -32'd1, 31'h7fff_ffff);
    endtask

    task automatic test_random_requests(int count);
        logic [2:0] md;
        for (int i = 0; i < count; i++)
        begin
            md = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            send_request(md, pick_word(), pick_word(), pick_word(), pick_den());
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        fail_count     = 0;
        idle_enable    = 1'b1;
        timed_out      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        wait_drained();              // sender holds off until all results are in
        test_random_requests(1400);
        idle_enable = 1'b0;          // final stretch runs back to back
        test_random_requests(425);
        wait_drained();
        repeat (500) @(posedge clk);

        if (fail_count == 0 && expected_q.size() == 0)
            $display("rational_arithmetic_unit: match");
        else
            $display("rational_arithmetic_unit: mismatch");
        $finish;
    end

endmodule

>>> sim.f
hdl/rau_pkg.sv
hdl/rau_stream_if.sv
hdl/rational_arithmetic_unit.sv
tb/tb_rational_arithmetic_unit.sv
